FILE: src/stcc_pkg.sv
// Shared types and constants for the slot timer with compare and capture.
package stcc_pkg;

    // Operation codes carried by each input item.
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_CAPTURE  = 3'd1,
        OP_SCHEDULE = 3'd2,
        OP_CANCEL   = 3'd3,
        OP_READ     = 3'd4,
        OP_CLEAR    = 3'd5,
        OP_IRQ_EN   = 3'd6,
        OP_IRQ_DIS  = 3'd7
    } t_op;

    localparam int unsigned FIELD_W = 16;
    localparam logic [FIELD_W-1:0] SLOT_RESET = 16'd491;

    typedef struct packed {
        t_op                operation;
        logic [FIELD_W-1:0] compare_offset;
    } t_item;

    typedef struct packed {
        logic               slot_edge;
        logic               compare_fire;
        logic               capture_irq;
        logic [FIELD_W-1:0] captured_time;
        logic               capture_valid;
        logic [FIELD_W-1:0] counter_value;
    } t_result;

endpackage

FILE: src/slot_timer_compare_capture.sv
// Top level of the slot timer with one compare and one capture channel.
//
// Slot timer in up mode. Each item carries an operation (tick, capture edge,
// schedule, cancel, read, clear, irq enable, irq disable) and a compare offset,
// and gives exactly one result. A tick advances the counter; a tick that finds
// the counter at or above slot_duration returns it to zero and raises
// slot_edge, so a slot is slot_duration + 1 ticks. An armed compare raises
// compare_fire on a tick whose new count equals the scheduled offset, in every
// slot until cancelled. A capture edge latches the counter and sets the capture
// flag; a second one before a clear sets overflow, which drops capture_valid.
// All result fields show state after the item. Rate: one item per clock while
// the result side is ready; each item passes the input register, then the
// result register, with the counter update and compare as the combinational
// path between them. Either side may stall without loss. slot_duration is
// written on the always-ready cfg channel; the user must write it only while
// no item is in flight, which the block does not enforce; it resets to 491.
// COUNT_WIDTH (8 to 32) sets the counter width; outputs show its low 16 bits.
module slot_timer_compare_capture #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_slot_duration,
    // item input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_compare_offset,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_slot_edge,
    output logic        o_compare_fire,
    output logic        o_capture_irq,
    output logic [15:0] o_captured_time,
    output logic        o_capture_valid,
    output logic [15:0] o_counter_value
);
    import stcc_pkg::*;

    logic [15:0] r_slot_duration;
    t_item       in_item;
    t_item       st_item;
    logic        st_valid;
    logic        core_ready;
    t_result     result;

    // config register, taken in any cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_duration <= SLOT_RESET;
        end else if (i_cfg_valid) begin
            r_slot_duration <= i_cfg_slot_duration;
        end
    end

    assign in_item.operation      = t_op'(i_operation);
    assign in_item.compare_offset = i_compare_offset;

    // stage 1: item register
    stcc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .i_ready (core_ready),
        .o_item  (st_item)
    );

    // stage 2: state update and result register
    stcc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slot_duration (r_slot_duration),
        .i_valid         (st_valid),
        .o_ready         (core_ready),
        .i_item          (st_item),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result        (result)
    );

    assign o_slot_edge     = result.slot_edge;
    assign o_compare_fire  = result.compare_fire;
    assign o_capture_irq   = result.capture_irq;
    assign o_captured_time = result.captured_time;
    assign o_capture_valid = result.capture_valid;
    assign o_counter_value = result.counter_value;

endmodule

FILE: src/stcc_in_stage.sv
// Input register stage: holds one accepted item for the core.
module stcc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  stcc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output stcc_pkg::t_item o_item
);
    import stcc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // take a new item when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: src/stcc_core.sv
// Timer state, per-item update logic and result register.
module stcc_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_slot_duration,
    input  logic             i_valid,
    output logic             o_ready,
    input  stcc_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output stcc_pkg::t_result o_result
);
    import stcc_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

    logic [COUNT_WIDTH-1:0] r_count,   n_count;
    logic [COUNT_WIDTH-1:0] r_cmp,     n_cmp;
    logic                   r_armed,   n_armed;
    logic [COUNT_WIDTH-1:0] r_cap,     n_cap;
    logic                   r_flag,    n_flag;
    logic                   r_ovf,     n_ovf;
    logic                   r_irq_en,  n_irq_en;
    logic                   r_out_valid;
    t_result                r_res,     n_res;

    logic [COUNT_WIDTH-1:0] top;
    logic [COUNT_WIDTH-1:0] offset;
    logic [EXT_W-1:0]       count_ext;
    logic [EXT_W-1:0]       cap_ext;
    logic                   edge_hit;
    logic                   fire;
    logic                   accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign top     = COUNT_WIDTH'(i_slot_duration);
    assign offset  = COUNT_WIDTH'(i_item.compare_offset);

    always_comb begin
        n_count  = r_count;
        n_cmp    = r_cmp;
        n_armed  = r_armed;
        n_cap    = r_cap;
        n_flag   = r_flag;
        n_ovf    = r_ovf;
        n_irq_en = r_irq_en;
        edge_hit = 1'b0;
        fire     = 1'b0;
        case (i_item.operation)
            OP_TICK: begin
                if (r_count >= top) begin
                    n_count  = '0;
                    edge_hit = 1'b1;
                end else begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
                fire = r_armed && (n_count == r_cmp);
            end
            OP_CAPTURE: begin
                n_ovf  = r_ovf || r_flag;
                n_cap  = r_count;
                n_flag = 1'b1;
            end
            OP_SCHEDULE: begin
                n_cmp   = offset;
                n_armed = 1'b1;
            end
            OP_CANCEL: begin
                n_cmp   = '0;
                n_armed = 1'b0;
            end
            OP_READ: begin
            end
            OP_CLEAR: begin
                n_flag = 1'b0;
                n_ovf  = 1'b0;
            end
            OP_IRQ_EN: begin
                n_irq_en = 1'b1;
            end
            default: begin
                n_irq_en = 1'b0;
            end
        endcase

        count_ext = EXT_W'(n_count);
        cap_ext   = EXT_W'(n_cap);
        n_res.slot_edge     = edge_hit;
        n_res.compare_fire  = fire;
        n_res.capture_irq   = n_flag && n_irq_en;
        n_res.captured_time = cap_ext[FIELD_W-1:0];
        n_res.capture_valid = !n_ovf;
        n_res.counter_value = count_ext[FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp       <= '0;
            r_armed     <= 1'b0;
            r_cap       <= '0;
            r_flag      <= 1'b0;
            r_ovf       <= 1'b0;
            r_irq_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count  <= n_count;
                r_cmp    <= n_cmp;
                r_armed  <= n_armed;
                r_cap    <= n_cap;
                r_flag   <= n_flag;
                r_ovf    <= n_ovf;
                r_irq_en <= n_irq_en;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // a wrap always leaves the counter at zero
    a_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.slot_edge) |-> (r_res.counter_value == '0))
        else $error("slot edge with nonzero counter");

    // overflow can only be set while the capture flag is set
    a_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_flag)
        else $error("capture overflow without capture flag");

    // a compare pulse needs an armed channel; nothing changes it while shown
    a_fire_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.compare_fire) |-> r_armed)
        else $error("compare fire while disarmed");

    // every accepted item leaves a result in the register
    a_acc_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // a held result does not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_res))
        else $error("held result changed");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the slot timer with compare and capture channels.
module tb;
    import stcc_pkg::*;

    // Generous run limit in clock cycles. About 1.1k items, each worst case a
    // long sender gap, a long receiver stall and the pass through both
    // registers, plus one long hold-off and the drain pauses.
    localparam int CYCLE_LIMIT = 600_000;
    localparam int DRAIN_LIMIT = 2_000;
    localparam int HOLD_CYCLES = 160;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_slot_duration;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [15:0] i_compare_offset;
    logic        o_valid;
    logic        i_ready;
    logic        o_slot_edge;
    logic        o_compare_fire;
    logic        o_capture_irq;
    logic [15:0] o_captured_time;
    logic        o_capture_valid;
    logic [15:0] o_counter_value;

    slot_timer_compare_capture i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_slot_duration (i_cfg_slot_duration),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_operation         (i_operation),
        .i_compare_offset    (i_compare_offset),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_slot_edge         (o_slot_edge),
        .o_compare_fire      (o_compare_fire),
        .o_capture_irq       (o_capture_irq),
        .o_captured_time     (o_captured_time),
        .o_capture_valid     (o_capture_valid),
        .o_counter_value     (o_counter_value)
    );

    // Timer state as the block should hold it. Updated at each item acceptance.
    logic [15:0] slot_len   = SLOT_RESET;
    logic [15:0] tick_cnt   = '0;
    logic [15:0] cmp_offset = '0;
    logic        cmp_armed  = 1'b0;
    logic [15:0] cap_time   = '0;
    logic        cap_flag   = 1'b0;
    logic        cap_ovf    = 1'b0;
    logic        irq_en     = 1'b0;

    // Results owed by the block, oldest first.
    t_result pending_results[$];

    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int hold_off_req  = 0;   // receiver picks this up and holds ready low
    bit tx_gapless    = 1'b0; // sender offers back to back
    bit rx_never_stall = 1'b0; // receiver always ready

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Global watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly zero, sometimes short, rarely a long stretch.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // Applies one item to the timer state and returns the result it owes.
    function automatic t_result advance_timer(t_op op, logic [15:0] offset);
        t_result res;
        res = '0;
        case (op)
            OP_TICK: begin
                // at or above top (top may have been lowered) -> wrap
                if (tick_cnt >= slot_len) begin
                    tick_cnt = '0;
                    res.slot_edge = 1'b1;
                end else begin
                    tick_cnt = tick_cnt + 16'd1;
                end
                res.compare_fire = cmp_armed && (tick_cnt == cmp_offset);
            end
            OP_CAPTURE: begin
                if (cap_flag) cap_ovf = 1'b1;
                cap_time = tick_cnt;
                cap_flag = 1'b1;
            end
            OP_SCHEDULE: begin
                cmp_offset = offset;
                cmp_armed  = 1'b1;
            end
            OP_CANCEL: begin
                cmp_offset = '0;
                cmp_armed  = 1'b0;
            end
            OP_READ: ;
            OP_CLEAR: begin
                cap_flag = 1'b0;
                cap_ovf  = 1'b0;
            end
            OP_IRQ_EN:  irq_en = 1'b1;
            OP_IRQ_DIS: irq_en = 1'b0;
            default: ;
        endcase
        res.capture_irq   = cap_flag && irq_en;
        res.captured_time = cap_time;
        res.capture_valid = !cap_ovf;
        res.counter_value = tick_cnt;
        return res;
    endfunction

    // Sends one item. Called right after posedge i_clk; valid is left high on
    // return so a back-to-back item just swaps the payload.
    task automatic send_item(t_op op, logic [15:0] offset);
        int gap;
        gap = tx_gapless ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_compare_offset <= offset;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(advance_timer(op, offset));
    endtask

    // Waits for all owed results, then writes the slot length.
    task automatic write_slot(logic [15:0] value);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        // items always produce a result, but let the pipe settle anyway
        repeat (3) @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_slot_duration <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        slot_len = value;
    endtask

    // Receiver: random stalls, plus long hold-offs on request.
    initial begin : rx_driver
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req > 0) begin
                stall_left   = hold_off_req;
                hold_off_req = 0;
            end
            if (stall_left == 0 && !rx_never_stall)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_slot_edge !== want.slot_edge)
                    report_mismatch("slot_edge", o_slot_edge, want.slot_edge);
                if (o_compare_fire !== want.compare_fire)
                    report_mismatch("compare_fire", o_compare_fire, want.compare_fire);
                if (o_capture_irq !== want.capture_irq)
                    report_mismatch("capture_irq", o_capture_irq, want.capture_irq);
                if (o_captured_time !== want.captured_time)
                    report_mismatch("captured_time", o_captured_time, want.captured_time);
                if (o_capture_valid !== want.capture_valid)
                    report_mismatch("capture_valid", o_capture_valid, want.capture_valid);
                if (o_counter_value !== want.counter_value)
                    report_mismatch("counter_value", o_counter_value, want.counter_value);
            end
        end
    end

    // Walks every operation by hand on a short slot, including a compare at
    // offset zero (fires on the wrap), capture overflow, irq gating, a top
    // lowered below the running count, and a zero slot length.
    task automatic test_directed();
        write_slot(16'd4);
        send_item(OP_READ, 16'hFFFF);     // reset view, offset ignored
        send_item(OP_SCHEDULE, 16'h0000);
        repeat (5) send_item(OP_TICK, 16'hFFFF);  // 1..4 then wrap + fire
        send_item(OP_SCHEDULE, 16'd2);
        repeat (2) send_item(OP_TICK, 16'h0000);  // fires at 2
        send_item(OP_CAPTURE, 16'h0000);
        send_item(OP_IRQ_EN, 16'h0000);
        send_item(OP_CAPTURE, 16'hFFFF);  // second capture -> overflow
        send_item(OP_READ, 16'h0000);
        send_item(OP_IRQ_DIS, 16'h0000);
        send_item(OP_CLEAR, 16'h0000);
        send_item(OP_CANCEL, 16'h5A5A);
        send_item(OP_TICK, 16'h0000);     // count 3, disarmed
        send_item(OP_SCHEDULE, 16'hFFFF); // never reachable here
        send_item(OP_TICK, 16'h0000);
        // count is 4; lowering top below it forces a wrap on the next tick
        write_slot(16'd1);
        send_item(OP_TICK, 16'h0000);
        // zero slot length: every tick wraps, offset zero fires every tick
        write_slot(16'd0);
        send_item(OP_SCHEDULE, 16'h0000);
        repeat (3) send_item(OP_TICK, 16'h0000);
    endtask

    // Longest slot: counter climbs without wrapping, compare mid-slot.
    task automatic test_long_slot();
        write_slot(16'hFFFF);
        send_item(OP_CANCEL, 16'h0000);
        send_item(OP_SCHEDULE, 16'd37);
        repeat (60) send_item(OP_TICK, 16'($urandom_range(0, 16'hFFFF)));
        send_item(OP_CAPTURE, 16'h0000);
        send_item(OP_READ, 16'h0000);
    endtask

    // Receiver holds off long enough that the block fills and stalls input,
    // while the sender keeps offering.
    task automatic test_backpressure();
        write_slot(16'd6);
        tx_gapless   = 1'b1;
        hold_off_req = HOLD_CYCLES;
        repeat (30) send_item(OP_TICK, 16'h0000);
        tx_gapless = 1'b0;
    endtask

    // No idling on either side.
    task automatic test_burst();
        write_slot(16'd3);
        tx_gapless     = 1'b1;
        rx_never_stall = 1'b1;
        send_item(OP_SCHEDULE, 16'd1);
        repeat (80) send_item(OP_TICK, 16'h0000);
        tx_gapless     = 1'b0;
        rx_never_stall = 1'b0;
    endtask

    // Random traffic on one slot setting. Ticks dominate so compares and
    // wraps keep happening; offsets mostly land inside the slot.
    task automatic test_random_traffic(logic [15:0] slot, int n_items);
        int roll;
        int reach;
        t_op op;
        logic [15:0] offset;
        write_slot(slot);
        reach = (slot > 16'd64) ? 64 : int'(slot) + 1;
        repeat (n_items) begin
            roll   = $urandom_range(0, 99);
            offset = 16'($urandom_range(0, 16'hFFFF));
            if (roll < 55)      op = OP_TICK;
            else if (roll < 63) op = OP_CAPTURE;
            else if (roll < 70) op = OP_SCHEDULE;
            else if (roll < 74) op = OP_CANCEL;
            else if (roll < 82) op = OP_READ;
            else if (roll < 89) op = OP_CLEAR;
            else if (roll < 94) op = OP_IRQ_EN;
            else                op = OP_IRQ_DIS;
            if (op == OP_SCHEDULE && $urandom_range(0, 3) != 0)
                offset = 16'($urandom_range(0, reach));
            send_item(op, offset);
        end
    endtask

    // Drain, settle, verdict.
    task automatic finish_run();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_operation         <= OP_TICK;
        i_compare_offset    <= '0;
        i_cfg_valid         <= 1'b0;
        i_cfg_slot_duration <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_slot();
        test_backpressure();
        test_burst();
        test_random_traffic(16'd1, 150);
        test_random_traffic(16'd9, 200);
        test_random_traffic(16'($urandom_range(2, 30)), 200);
        test_random_traffic(16'd0, 100);
        test_random_traffic(SLOT_RESET, 150);
        test_random_traffic(16'hFFFF, 100);
        finish_run();
    end

endmodule
